### hdl/eslp_pkg.sv
// ----------------------------------------------------------------------------
// Event stream line parser package
// Shared types and character constants for the line parser and its checker.
// ----------------------------------------------------------------------------
package eslp_pkg;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam int              EV_CHARS   = 5;
  localparam int              DA_CHARS   = 4;
  localparam logic [8*EV_CHARS-1:0] NAME_EVENT = "event";
  localparam logic [8*DA_CHARS-1:0] NAME_DATA  = "data";

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_TYPE = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  typedef logic [3:0] match_t;

  localparam match_t FM_START   = 4'd0;
  localparam match_t FM_EV_LO   = 4'd1;
  localparam match_t FM_EV_HI   = 4'd4;
  localparam match_t FM_EVENT   = 4'd5;
  localparam match_t FM_DA_LO   = 4'd6;
  localparam match_t FM_DA_HI   = 4'd8;
  localparam match_t FM_DATA    = 4'd9;
  localparam match_t FM_NONE    = 4'd15;

  typedef enum logic [2:0] {
    PH_START,
    PH_NAME,
    PH_VSTART,
    PH_VALUE,
    PH_SKIP
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SECOND,
    ST_REPLAY,
    ST_END
  } ctrl_e;

  typedef struct packed {
    phase_e phase;
    match_t fm;
    logic   pcr;
    logic   dseen;
  } line_t;

  typedef struct packed {
    logic       res_a;
    logic [7:0] res_a_byte;
    logic       res_b;
    logic [7:0] res_b_byte;
    logic       put_a;
    logic [7:0] put_a_byte;
    logic       put_b;
    logic [7:0] put_b_byte;
    logic       type_clr;
    logic       blank;
    line_t      line;
  } dec_t;

endpackage

### hdl/event_stream_line_parser.sv
// ----------------------------------------------------------------------------
// Event stream line parser
// Results are registered; type bytes are replayed from a registered store read.
// Throughput: one byte per cycle while the output is not stalled. A byte that
// releases a held CR together with a value byte stalls the input for a second
// state; a blank line that dispatches a stored type stalls it during replay.
// Reset: asynchronous, active low; clears line state and control, not the
// type store, whose unwritten entries are never read.
// ----------------------------------------------------------------------------
module event_stream_line_parser #(
  parameter int MAX_TYPE_LEN = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] stream_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] item_kind_o,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output logic       type_truncated_o
);

  localparam int AW = (MAX_TYPE_LEN > 1) ? $clog2(MAX_TYPE_LEN) : 1;
  localparam int LW = $clog2(MAX_TYPE_LEN + 1);
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_TYPE_LEN);

  eslp_pkg::dec_t  dec;
  eslp_pkg::line_t line_q, line_d;
  eslp_pkg::ctrl_e state_q, state_d;

  logic [LW-1:0] tlen_q, tlen_d, tlen_a;
  logic          tovf_q, tovf_d;
  logic          a_ok, b_ok, dispatch;
  logic          can_load, acc;

  logic          out_valid_q, out_valid_d;
  logic [1:0]    kind_q;
  logic [7:0]    obyte_q;
  logic          last_q, trunc_q;

  logic          load, ld_last, ld_trunc;
  logic [1:0]    ld_kind;
  logic [7:0]    ld_byte;

  logic          hold_q;
  logic [7:0]    hold_byte_q;
  logic          wpend_q;
  logic [AW-1:0] wpend_addr_q;
  logic [7:0]    wpend_data_q;

  logic [LW-1:0] rep_idx_q, rep_idx_d, rep_next, rep_len_q;
  logic          rep_ovf_q, rep_last;

  logic [7:0]    mem [MAX_TYPE_LEN];
  logic [7:0]    rd_data_q;
  logic [AW-1:0] rd_addr, waddr;
  logic [7:0]    wdata;
  logic          we;

  eslp_decode u_decode (
    .line_i (line_q),
    .byte_i (stream_byte_i),
    .dec_o  (dec)
  );

  assign can_load   = !out_valid_q || !out_stall_i;
  assign acc        = in_valid_i && (state_q == eslp_pkg::ST_IDLE) && can_load;
  assign in_stall_o = !((state_q == eslp_pkg::ST_IDLE) && can_load);
  assign rep_next   = rep_idx_q + LW'(1);
  assign rep_last   = (rep_next == rep_len_q);

  always_comb begin
    a_ok     = dec.put_a && (tlen_q < LEN_MAX);
    tlen_a   = tlen_q + LW'(a_ok);
    b_ok     = dec.put_b && (tlen_a < LEN_MAX);
    dispatch = dec.blank && (line_q.dseen || (tlen_q != '0));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      eslp_pkg::ST_IDLE: begin
        if (acc) begin
          if (dispatch && (tlen_q != '0)) begin
            state_d = eslp_pkg::ST_REPLAY;
          end else if (dec.res_b || b_ok) begin
            state_d = eslp_pkg::ST_SECOND;
          end
        end
      end
      eslp_pkg::ST_SECOND: begin
        if (!hold_q || can_load) begin
          state_d = eslp_pkg::ST_IDLE;
        end
      end
      eslp_pkg::ST_REPLAY: begin
        if (can_load && rep_last) begin
          state_d = eslp_pkg::ST_END;
        end
      end
      eslp_pkg::ST_END: begin
        if (can_load) begin
          state_d = eslp_pkg::ST_IDLE;
        end
      end
      default: state_d = eslp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    line_d    = line_q;
    tlen_d    = tlen_q;
    tovf_d    = tovf_q;
    rep_idx_d = rep_idx_q;
    load      = 1'b0;
    ld_kind   = eslp_pkg::KIND_DATA;
    ld_byte   = 8'h00;
    ld_last   = 1'b0;
    ld_trunc  = 1'b0;
    we        = 1'b0;
    waddr     = tlen_q[AW-1:0];
    wdata     = dec.put_a_byte;
    rd_addr   = '0;
    case (state_q)
      eslp_pkg::ST_IDLE: begin
        if (acc) begin
          line_d    = dec.line;
          tlen_d    = tlen_a + LW'(b_ok);
          tovf_d    = tovf_q | (dec.put_a && !a_ok) | (dec.put_b && !b_ok);
          rep_idx_d = '0;
          if (dec.type_clr || dec.blank) begin
            tlen_d = '0;
            tovf_d = 1'b0;
          end
          we = a_ok;
          if (dispatch && (tlen_q == '0)) begin
            load     = 1'b1;
            ld_kind  = eslp_pkg::KIND_END;
            ld_last  = 1'b1;
            ld_trunc = tovf_q;
          end else if (dec.res_a) begin
            load    = 1'b1;
            ld_byte = dec.res_a_byte;
            ld_last = !dec.res_b;
          end
        end
      end
      eslp_pkg::ST_SECOND: begin
        we    = wpend_q;
        waddr = wpend_addr_q;
        wdata = wpend_data_q;
        if (hold_q && can_load) begin
          load    = 1'b1;
          ld_byte = hold_byte_q;
          ld_last = 1'b1;
        end
      end
      eslp_pkg::ST_REPLAY: begin
        rd_addr = rep_idx_q[AW-1:0];
        if (can_load) begin
          load      = 1'b1;
          ld_kind   = eslp_pkg::KIND_TYPE;
          ld_byte   = rd_data_q;
          rep_idx_d = rep_next;
          if (!rep_last) begin
            rd_addr = rep_next[AW-1:0];
          end
        end
      end
      eslp_pkg::ST_END: begin
        if (can_load) begin
          load     = 1'b1;
          ld_kind  = eslp_pkg::KIND_END;
          ld_last  = 1'b1;
          ld_trunc = rep_ovf_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_d = load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= eslp_pkg::ST_IDLE;
      line_q      <= '{phase: eslp_pkg::PH_START, fm: eslp_pkg::FM_START,
                       pcr: 1'b0, dseen: 1'b0};
      tlen_q      <= '0;
      tovf_q      <= 1'b0;
      out_valid_q <= 1'b0;
      hold_q      <= 1'b0;
      wpend_q     <= 1'b0;
      rep_idx_q   <= '0;
    end else begin
      state_q     <= state_d;
      line_q      <= line_d;
      tlen_q      <= tlen_d;
      tovf_q      <= tovf_d;
      out_valid_q <= out_valid_d;
      rep_idx_q   <= rep_idx_d;
      if (acc) begin
        hold_q  <= dec.res_b;
        wpend_q <= b_ok;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= ld_kind;
      obyte_q <= ld_byte;
      last_q  <= ld_last;
      trunc_q <= ld_trunc;
    end
    if (acc) begin
      hold_byte_q  <= dec.res_b_byte;
      wpend_addr_q <= tlen_a[AW-1:0];
      wpend_data_q <= dec.put_b_byte;
      rep_len_q    <= tlen_q;
      rep_ovf_q    <= tovf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_q <= mem[rd_addr];
  end

  assign out_valid_o      = out_valid_q;
  assign item_kind_o      = kind_q;
  assign out_byte_o       = obyte_q;
  assign last_o           = last_q;
  assign type_truncated_o = trunc_q;

endmodule

### hdl/eslp_decode.sv
// ----------------------------------------------------------------------------
// Event stream line decoder
// Applies one stream byte to the line state: held CR, field name match,
// value bytes, and line end. Reports data bytes and type store writes.
// ----------------------------------------------------------------------------
module eslp_decode (
  input  eslp_pkg::line_t     line_i,
  input  logic [7:0]          byte_i,
  output eslp_pkg::dec_t      dec_o
);

  typedef struct packed {
    eslp_pkg::line_t line;
    logic            res;
    logic [7:0]      rbyte;
    logic            put;
    logic            clr;
  } step_t;

  function automatic logic [7:0] exp_char(eslp_pkg::match_t fm);
    logic [7:0] r;
    int         k;
    r = 8'h00;
    k = int'(fm);
    if (fm inside {[eslp_pkg::FM_EV_LO:eslp_pkg::FM_EV_HI]}) begin
      r = eslp_pkg::NAME_EVENT[8*(eslp_pkg::EV_CHARS-1-k) +: 8];
    end else if (fm inside {[eslp_pkg::FM_DA_LO:eslp_pkg::FM_DA_HI]}) begin
      k = k - int'(eslp_pkg::FM_DA_LO) + 1;
      r = eslp_pkg::NAME_DATA[8*(eslp_pkg::DA_CHARS-1-k) +: 8];
    end
    return r;
  endfunction

  function automatic eslp_pkg::match_t adv(eslp_pkg::match_t fm, logic [7:0] c);
    eslp_pkg::match_t r;
    r = eslp_pkg::FM_NONE;
    if (fm == eslp_pkg::FM_START) begin
      if (c == eslp_pkg::NAME_EVENT[8*eslp_pkg::EV_CHARS-1 -: 8]) begin
        r = eslp_pkg::FM_EV_LO;
      end else if (c == eslp_pkg::NAME_DATA[8*eslp_pkg::DA_CHARS-1 -: 8]) begin
        r = eslp_pkg::FM_DA_LO;
      end
    end else if ((fm inside {[eslp_pkg::FM_EV_LO:eslp_pkg::FM_EV_HI],
                             [eslp_pkg::FM_DA_LO:eslp_pkg::FM_DA_HI]})
                 && (c == exp_char(fm))) begin
      r = fm + 4'd1;
    end
    return r;
  endfunction

  function automatic step_t idle_step(eslp_pkg::line_t s);
    step_t o;
    o.line  = s;
    o.res   = 1'b0;
    o.rbyte = 8'h00;
    o.put   = 1'b0;
    o.clr   = 1'b0;
    return o;
  endfunction

  function automatic step_t content(eslp_pkg::line_t s, logic [7:0] c);
    step_t o;
    o       = idle_step(s);
    o.rbyte = c;
    case (s.phase)
      eslp_pkg::PH_START: begin
        if (c == eslp_pkg::CH_COLON) begin
          o.line.phase = eslp_pkg::PH_SKIP;
        end else begin
          o.line.phase = eslp_pkg::PH_NAME;
          o.line.fm    = adv(eslp_pkg::FM_START, c);
        end
      end
      eslp_pkg::PH_NAME: begin
        if (c == eslp_pkg::CH_COLON) begin
          if (s.fm == eslp_pkg::FM_EVENT) begin
            o.clr        = 1'b1;
            o.line.phase = eslp_pkg::PH_VSTART;
          end else if (s.fm == eslp_pkg::FM_DATA) begin
            o.res        = s.dseen;
            o.rbyte      = eslp_pkg::CH_LF;
            o.line.dseen = 1'b1;
            o.line.phase = eslp_pkg::PH_VSTART;
          end else begin
            o.line.phase = eslp_pkg::PH_SKIP;
          end
        end else begin
          o.line.fm = adv(s.fm, c);
        end
      end
      eslp_pkg::PH_VSTART: begin
        o.line.phase = eslp_pkg::PH_VALUE;
        if (c != eslp_pkg::CH_SPACE) begin
          o.res = (s.fm == eslp_pkg::FM_DATA);
          o.put = (s.fm == eslp_pkg::FM_EVENT);
        end
      end
      eslp_pkg::PH_VALUE: begin
        o.res = (s.fm == eslp_pkg::FM_DATA);
        o.put = (s.fm == eslp_pkg::FM_EVENT);
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  step_t s1;
  step_t s2;

  always_comb begin
    s1 = line_i.pcr ? content(line_i, eslp_pkg::CH_CR) : idle_step(line_i);
    s2 = (byte_i != eslp_pkg::CH_CR) ? content(s1.line, byte_i) : idle_step(s1.line);

    dec_o            = '0;
    dec_o.line       = line_i;
    dec_o.res_a_byte = eslp_pkg::CH_LF;

    if (byte_i == eslp_pkg::CH_LF) begin
      dec_o.line.pcr   = 1'b0;
      dec_o.line.phase = eslp_pkg::PH_START;
      dec_o.line.fm    = eslp_pkg::FM_START;
      if (line_i.phase == eslp_pkg::PH_START) begin
        dec_o.blank      = 1'b1;
        dec_o.line.dseen = 1'b0;
      end else if (line_i.phase == eslp_pkg::PH_NAME) begin
        if (line_i.fm == eslp_pkg::FM_EVENT) begin
          dec_o.type_clr = 1'b1;
        end else if (line_i.fm == eslp_pkg::FM_DATA) begin
          dec_o.res_a      = line_i.dseen;
          dec_o.line.dseen = 1'b1;
        end
      end
    end else begin
      dec_o.line       = s2.line;
      dec_o.line.pcr   = (byte_i == eslp_pkg::CH_CR);
      dec_o.res_a      = s1.res | s2.res;
      dec_o.res_a_byte = s1.res ? s1.rbyte : s2.rbyte;
      dec_o.res_b      = s1.res & s2.res;
      dec_o.res_b_byte = s2.rbyte;
      dec_o.put_a      = s1.put | s2.put;
      dec_o.put_a_byte = s1.put ? s1.rbyte : s2.rbyte;
      dec_o.put_b      = s1.put & s2.put;
      dec_o.put_b_byte = s2.rbyte;
      dec_o.type_clr   = s1.clr | s2.clr;
    end
  end

endmodule

### hdl/eslp_checker.sv
// ----------------------------------------------------------------------------
// Event stream line parser checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module eslp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] item_kind_o,
  input logic [7:0] out_byte_o,
  input logic       last_o,
  input logic       type_truncated_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(item_kind_o)
      && $stable(out_byte_o) && $stable(last_o) && $stable(type_truncated_o))
    else $error("result changed while stalled");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (item_kind_o == eslp_pkg::KIND_END) |->
      last_o && (out_byte_o == 8'h00))
    else $error("end item not last or carries a byte");

  a_type_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (item_kind_o == eslp_pkg::KIND_TYPE) |-> !last_o)
    else $error("type byte marked last");

  a_trunc_end_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (item_kind_o != eslp_pkg::KIND_END) |-> !type_truncated_o)
    else $error("truncation flag outside end item");

endmodule

bind event_stream_line_parser eslp_checker u_eslp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .item_kind_o      (item_kind_o),
  .out_byte_o       (out_byte_o),
  .last_o           (last_o),
  .type_truncated_o (type_truncated_o)
);
